[hw/rtl/vt_escape_sequence_parser_assert.svh]
// Assertion macros for the escape sequence parser.
`ifndef VT_ESCAPE_SEQUENCE_PARSER_ASSERT_SVH
`define VT_ESCAPE_SEQUENCE_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define VTP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VTP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VTP_ASSERT_IMP(label, clk, rstn, ante, cons)
`define VTP_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/vtp_pkg.sv]
// Shared types and constants of the escape sequence parser.
`default_nettype none
package vtp_pkg;
    localparam int MAX_PARAMS_DEF = 16;
    localparam int PARAM_BITS_DEF = 16;

    typedef enum logic [3:0] {
        M_GROUND, M_ESC, M_ESC_INTER, M_CSI_ENTRY, M_CSI_PARAM,
        M_CSI_INTER, M_CSI_IGNORE, M_OSC, M_STR_IGNORE
    } mode_t;

    typedef enum logic [2:0] {
        K_PRINT = 3'd0, K_EXEC = 3'd1, K_ESC = 3'd2, K_CSI = 3'd3, K_OSC = 3'd4
    } kind_t;

    localparam logic [7:0] B_ESC = 8'h1B;
    localparam logic [7:0] B_CAN = 8'h18;
    localparam logic [7:0] B_SUB = 8'h1A;
    localparam logic [7:0] B_ST = 8'h9C;
    localparam logic [7:0] B_BEL = 8'h07;
    localparam logic [20:0] CP_REPL = 21'h00FFFD;

    // Event handed from front to back: simple events carry code only.
    typedef struct packed {
        kind_t kind;
        logic [20:0] code;
        logic [7:0] pmark;
        logic [7:0] inter;
    } event_t;
endpackage
`default_nettype wire

[hw/rtl/vtp_front.sv]
// Front end: byte classification, mode machine, UTF-8 decode, parameter capture.
`default_nettype none
module vtp_front #(
    parameter int MAX_PARAMS = vtp_pkg::MAX_PARAMS_DEF,
    parameter int PARAM_BITS = vtp_pkg::PARAM_BITS_DEF,
    localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1,
    localparam int CW = $clog2(MAX_PARAMS + 1)
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    input  wire logic [7:0] in_byte,
    output logic in_ready,
    output logic ev_valid,
    output vtp_pkg::event_t ev_data,
    output logic [CW-1:0] ev_count,
    input  wire logic ev_ready,
    output logic pw_en,
    output logic [IW-1:0] pw_addr,
    output logic [PARAM_BITS-1:0] pw_data
);
    localparam logic [PARAM_BITS-1:0] PMAX = '1;
    vtp_pkg::mode_t mode_reg, mode_next;
    logic [20:0] acc_reg, acc_next;
    logic [1:0] left_reg, left_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [PARAM_BITS-1:0] dig_reg, dig_next;
    logic seen_reg, seen_next;
    logic [7:0] pm_reg, pm_next, ci_reg, ci_next;
    logic emit;
    logic [PARAM_BITS+3:0] prod;
    logic [PARAM_BITS-1:0] dsat;
    logic push;
    logic [PARAM_BITS-1:0] push_val;
    logic clr;
    logic fire;
    logic [7:0] b;

    assign b = in_byte;
    assign in_ready = ev_ready;
    assign fire = in_valid && in_ready;
    assign prod = {4'd0, dig_reg} * (PARAM_BITS+4)'(10) + (PARAM_BITS+4)'(b - 8'h30);
    assign dsat = (prod > {4'd0, PMAX}) ? PMAX : prod[PARAM_BITS-1:0];

    always_comb begin
        mode_next = mode_reg; acc_next = acc_reg; left_next = left_reg;
        dig_next = dig_reg; seen_next = seen_reg; pm_next = pm_reg; ci_next = ci_reg;
        emit = 1'b0; push = 1'b0; push_val = '0; clr = 1'b0;
        ev_data = '{kind: vtp_pkg::K_PRINT, code: 21'd0, pmark: 8'd0, inter: 8'd0};
        if (b == vtp_pkg::B_ESC) begin
            acc_next = '0; left_next = '0; clr = 1'b1; mode_next = vtp_pkg::M_ESC;
        end else if (b == vtp_pkg::B_CAN || b == vtp_pkg::B_SUB) begin
            acc_next = '0; left_next = '0; mode_next = vtp_pkg::M_GROUND;
        end else begin
            unique case (mode_reg)
                vtp_pkg::M_GROUND: begin
                    emit = 1'b1;
                    if (b < 8'h20 || b == 8'h7F) begin
                        ev_data.kind = vtp_pkg::K_EXEC; ev_data.code = {13'd0, b};
                    end else if (left_reg != 2'd0 && b[7:6] == 2'b10) begin
                        acc_next = {acc_reg[14:0], b[5:0]};
                        left_next = left_reg - 2'd1;
                        ev_data.code = {acc_reg[14:0], b[5:0]};
                        emit = (left_reg == 2'd1);
                    end else begin
                        left_next = '0; acc_next = '0;
                        if (!b[7]) ev_data.code = {13'd0, b};
                        else if (b[7:5] == 3'b110) begin
                            acc_next = {16'd0, b[4:0]}; left_next = 2'd1; emit = 1'b0;
                        end else if (b[7:4] == 4'b1110) begin
                            acc_next = {17'd0, b[3:0]}; left_next = 2'd2; emit = 1'b0;
                        end else if (b[7:3] == 5'b11110) begin
                            acc_next = {18'd0, b[2:0]}; left_next = 2'd3; emit = 1'b0;
                        end else ev_data.code = vtp_pkg::CP_REPL;
                    end
                end
                vtp_pkg::M_ESC: begin
                    if (b >= 8'h20 && b <= 8'h2F) mode_next = vtp_pkg::M_ESC_INTER;
                    else if (b == 8'h5B) begin
                        clr = 1'b1; mode_next = vtp_pkg::M_CSI_ENTRY;
                    end else if (b == 8'h5D) mode_next = vtp_pkg::M_OSC;
                    else if (b == 8'h50 || b == 8'h58 || b == 8'h5E || b == 8'h5F)
                        mode_next = vtp_pkg::M_STR_IGNORE;
                    else if (b >= 8'h30 && b <= 8'h7E) begin
                        mode_next = vtp_pkg::M_GROUND; emit = 1'b1;
                        ev_data.kind = vtp_pkg::K_ESC; ev_data.code = {13'd0, b};
                    end else if (b < 8'h20) begin
                        emit = 1'b1; ev_data.kind = vtp_pkg::K_EXEC;
                        ev_data.code = {13'd0, b};
                    end else mode_next = vtp_pkg::M_GROUND;
                end
                vtp_pkg::M_ESC_INTER:
                    if (b >= 8'h30 && b <= 8'h7E) mode_next = vtp_pkg::M_GROUND;
                vtp_pkg::M_CSI_ENTRY, vtp_pkg::M_CSI_PARAM, vtp_pkg::M_CSI_INTER: begin
                    ev_data.pmark = pm_reg; ev_data.inter = ci_reg;
                    ev_data.code = {13'd0, b};
                    if (b < 8'h20) begin
                        emit = 1'b1; ev_data = '{kind: vtp_pkg::K_EXEC,
                            code: {13'd0, b}, pmark: 8'd0, inter: 8'd0};
                    end else if (b >= 8'h40 && b <= 8'h7E) begin
                        emit = 1'b1; ev_data.kind = vtp_pkg::K_CSI;
                        mode_next = vtp_pkg::M_GROUND;
                        if (mode_reg == vtp_pkg::M_CSI_PARAM && seen_reg) begin
                            push = 1'b1; push_val = dig_reg;
                        end
                    end else if (mode_reg == vtp_pkg::M_CSI_INTER) begin
                        // swallow
                    end else if (b >= 8'h30 && b <= 8'h39) begin
                        seen_next = 1'b1; mode_next = vtp_pkg::M_CSI_PARAM;
                        dig_next = (mode_reg == vtp_pkg::M_CSI_ENTRY) ?
                            PARAM_BITS'(b - 8'h30) : dsat;
                    end else if (b == 8'h3B || b == 8'h3A) begin
                        push = 1'b1; push_val = seen_reg ? dig_reg : '0;
                        dig_next = '0; seen_next = 1'b0; mode_next = vtp_pkg::M_CSI_PARAM;
                    end else if (b >= 8'h3C && b <= 8'h3F && mode_reg == vtp_pkg::M_CSI_ENTRY)
                    begin
                        pm_next = b; mode_next = vtp_pkg::M_CSI_PARAM;
                    end else if (b >= 8'h20 && b <= 8'h2F) begin
                        if (mode_reg == vtp_pkg::M_CSI_PARAM && seen_reg) begin
                            push = 1'b1; push_val = dig_reg;
                        end
                        ci_next = b; mode_next = vtp_pkg::M_CSI_INTER;
                    end else mode_next = vtp_pkg::M_CSI_IGNORE;
                end
                vtp_pkg::M_CSI_IGNORE:
                    if (b >= 8'h40 && b <= 8'h7E) mode_next = vtp_pkg::M_GROUND;
                vtp_pkg::M_OSC:
                    if (b == vtp_pkg::B_BEL || b == vtp_pkg::B_ST) begin
                        mode_next = vtp_pkg::M_GROUND; emit = 1'b1;
                        ev_data.kind = vtp_pkg::K_OSC; ev_data.code = {13'd0, b};
                    end
                vtp_pkg::M_STR_IGNORE:
                    if (b == 8'h5C || b == vtp_pkg::B_BEL || b == vtp_pkg::B_ST)
                        mode_next = vtp_pkg::M_GROUND;
                default: mode_next = vtp_pkg::M_GROUND;
            endcase
        end
    end

    assign pw_en = fire && push && (fill_reg < CW'(MAX_PARAMS));
    assign pw_addr = fill_reg[IW-1:0];
    assign pw_data = push_val;
    assign fill_next = clr ? '0 : (pw_en ? fill_reg + CW'(1) : fill_reg);
    assign ev_valid = fire && emit;
    assign ev_count = pw_en ? fill_reg + CW'(1) : fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= vtp_pkg::M_GROUND; acc_reg <= '0; left_reg <= '0;
            fill_reg <= '0; dig_reg <= '0; seen_reg <= 1'b0; pm_reg <= '0; ci_reg <= '0;
        end else if (fire) begin
            mode_reg <= mode_next; acc_reg <= acc_next; left_reg <= left_next;
            fill_reg <= fill_next;
            dig_reg <= clr ? '0 : dig_next;
            seen_reg <= clr ? 1'b0 : seen_next;
            pm_reg <= clr ? '0 : pm_next;
            ci_reg <= clr ? '0 : ci_next;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/vtp_back.sv]
// Back end: event queue, parameter memory and result sequencer.
`default_nettype none
module vtp_back #(
    parameter int MAX_PARAMS = vtp_pkg::MAX_PARAMS_DEF,
    parameter int PARAM_BITS = vtp_pkg::PARAM_BITS_DEF,
    localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1,
    localparam int CW = $clog2(MAX_PARAMS + 1)
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic ev_valid,
    input  wire vtp_pkg::event_t ev_data,
    input  wire logic [CW-1:0] ev_count,
    output logic ev_ready,
    input  wire logic pw_en,
    input  wire logic [IW-1:0] pw_addr,
    input  wire logic [PARAM_BITS-1:0] pw_data,
    output logic m_valid,
    output vtp_pkg::event_t m_ev,
    output logic [CW-1:0] m_count,
    output logic [IW-1:0] m_index,
    output logic [PARAM_BITS-1:0] m_value,
    output logic m_last,
    input  wire logic m_ready
);
    logic [PARAM_BITS-1:0] mem [MAX_PARAMS];
    vtp_pkg::event_t q_ev_reg;
    logic [CW-1:0] q_cnt_reg;
    logic q_full_reg;
    logic busy_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic [PARAM_BITS-1:0] rd_reg;
    logic out_v_reg;
    logic take, adv, is_csi;

    // One queued event; the front stalls whenever an event is queued, also while the back is busy with it.
    assign ev_ready = !q_full_reg;
    assign is_csi = q_ev_reg.kind == vtp_pkg::K_CSI && q_cnt_reg != '0;
    assign adv = out_v_reg && m_ready;
    // Load next result when output is free.
    assign take = q_full_reg && (!out_v_reg || m_ready) && !(busy_reg && out_v_reg && !m_ready);
    assign idx_next = busy_reg ? idx_reg + CW'(1) : '0;

    // Hold the read data with the result it belongs to.
    always_ff @(posedge aclk) begin
        if (pw_en) mem[pw_addr] <= pw_data;
        if (take) rd_reg <= mem[idx_next[IW-1:0]];
    end

    logic [CW-1:0] cur_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_full_reg <= 1'b0; busy_reg <= 1'b0; out_v_reg <= 1'b0;
            idx_reg <= '0; cur_reg <= '0;
        end else begin
            if (adv) out_v_reg <= 1'b0;
            if (take) begin
                out_v_reg <= 1'b1;
                cur_reg <= idx_next;
                if (is_csi && (idx_next + CW'(1) != q_cnt_reg)) begin
                    busy_reg <= 1'b1; idx_reg <= idx_next;
                end else begin
                    busy_reg <= 1'b0; idx_reg <= '0; q_full_reg <= 1'b0;
                end
            end
            if (ev_valid) q_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_valid) begin
            q_ev_reg <= ev_data; q_cnt_reg <= ev_count;
        end
        if (take) begin
            m_ev <= q_ev_reg; m_count <= is_csi ? q_cnt_reg : '0;
            m_last <= !is_csi || (idx_next + CW'(1) == q_cnt_reg);
        end
    end

    assign m_valid = out_v_reg;
    assign m_index = cur_reg[IW-1:0];
    assign m_value = (m_ev.kind == vtp_pkg::K_CSI && m_count != '0) ? rd_reg : '0;
endmodule
`default_nettype wire

[hw/rtl/vt_escape_sequence_parser.sv]
// Top level of the terminal escape sequence parser.
//  channel | dir | handshake        | payload
//  s_      | in  | s_tvalid/tready  | tdata = in_byte[7:0]
//  m_      | out | m_tvalid/tready  | tuser = event_kind, tdata fields, tlast = last
// A byte that emits nothing is taken back to back while the queue is empty.
// A byte that emits an event fills the one-entry queue, which holds s_tready low
// until the output register loads the event.
// A CSI dispatch with n stored parameters loads one result per cycle while m_tready
// does not stall the output, and holds s_tready low until its last result loads.
// Reset is synchronous active low and clears mode and queue; params need none.
`default_nettype none
`include "vt_escape_sequence_parser_assert.svh"
module vt_escape_sequence_parser #(
    parameter int MAX_PARAMS = vtp_pkg::MAX_PARAMS_DEF,
    parameter int PARAM_BITS = vtp_pkg::PARAM_BITS_DEF,
    localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1,
    localparam int CW = $clog2(MAX_PARAMS + 1),
    localparam int DW = 21 + 16 + CW + IW + PARAM_BITS,
    localparam int TW = ((DW + 7) / 8) * 8
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic s_tready,
    input  wire logic [7:0] s_tdata, // in_byte
    output logic m_tvalid,
    input  wire logic m_tready,
    output logic [2:0] m_tuser, // event_kind
    // code, private_marker, inter_byte, param_count, param_index, param_value
    output logic [TW-1:0] m_tdata,
    output logic m_tlast
);
    logic ev_valid, ev_ready, pw_en;
    vtp_pkg::event_t ev_data, m_ev;
    logic [CW-1:0] ev_count, m_count;
    logic [IW-1:0] pw_addr, m_index;
    logic [PARAM_BITS-1:0] pw_data, m_value;

    vtp_front #(.MAX_PARAMS(MAX_PARAMS), .PARAM_BITS(PARAM_BITS)) u_front (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_byte(s_tdata), .in_ready(s_tready),
        .ev_valid, .ev_data, .ev_count, .ev_ready, .pw_en, .pw_addr, .pw_data);

    vtp_back #(.MAX_PARAMS(MAX_PARAMS), .PARAM_BITS(PARAM_BITS)) u_back (
        .aclk, .aresetn, .ev_valid, .ev_data, .ev_count, .ev_ready, .pw_en, .pw_addr,
        .pw_data, .m_valid(m_tvalid), .m_ev, .m_count, .m_index, .m_value,
        .m_last(m_tlast), .m_ready(m_tready));

    assign m_tuser = m_ev.kind;
    assign m_tdata = TW'({m_value, m_index, m_count, m_ev.inter, m_ev.pmark, m_ev.code});

    `VTP_ASSERT_IMP(a_ev_ready, aclk, aresetn, ev_valid, ev_ready)
    `VTP_ASSERT_IMP(a_last_simple, aclk, aresetn, m_tvalid && m_tuser != vtp_pkg::K_CSI, m_tlast)
    `VTP_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata, m_tlast}))
endmodule
`default_nettype wire

[tb/tb.sv]
// Testbench for the terminal escape sequence parser: directed table plus random byte streams.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = 21 + 8 + 8 + 5 + 4 + 16;
    localparam int TW = ((DW + 7) / 8) * 8;
    localparam int N_ITEMS = 210;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0] kind;
        logic [20:0] code;
        logic [7:0] pmark;
        logic [7:0] inter;
        logic [4:0] cnt;
        logic [3:0] idx;
        logic [15:0] val;
        logic last;
    } parse_event_t;

    typedef struct packed {
        logic [7:0] din;
        logic typed;
        logic [2:0] kind;
        logic [20:0] code;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [2:0] m_tuser;
    logic [TW-1:0] m_tdata;
    logic m_tlast;

    vt_escape_sequence_parser i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor state
    vtp_pkg::mode_t pmode;
    logic [20:0] u_acc;
    logic [1:0] u_left;
    logic [15:0] pstore [16];
    logic [4:0] pfill;
    logic [15:0] dacc;
    logic dseen;
    logic [7:0] pmk;
    logic [7:0] pint;

    parse_event_t pending_events[$];
    stim_row_t stim[$];
    int errors = 0;
    int n_results = 0;
    int n_csi = 0;
    int cycles = 0;

    function automatic parse_event_t simple_ev(logic [2:0] k, logic [20:0] c);
        parse_event_t e;
        e = '0;
        e.kind = k;
        e.code = c;
        e.last = 1'b1;
        return e;
    endfunction

    task automatic add_event(parse_event_t e);
        pending_events = {pending_events, e};
    endtask

    task automatic add_row(logic [7:0] din, logic typed, logic [2:0] k, logic [20:0] c);
        stim_row_t r;
        r.din = din;
        r.typed = typed;
        r.kind = k;
        r.code = c;
        stim = {stim, r};
    endtask

    task automatic add_byte(logic [7:0] din);
        add_row(din, 1'b0, 3'd0, 21'd0);
    endtask

    task automatic clear_csi();
        pfill = 0;
        dacc = 0;
        dseen = 0;
        pmk = 0;
        pint = 0;
    endtask

    task automatic push_param(logic [15:0] v);
        if (pfill < 5'd16) begin
            pstore[pfill[3:0]] = v;
            pfill = pfill + 5'd1;
        end
    endtask

    task automatic csi_dispatch(logic [7:0] fb);
        parse_event_t e;
        pmode = vtp_pkg::M_GROUND;
        n_csi++;
        e = simple_ev(vtp_pkg::K_CSI, {13'd0, fb});
        e.pmark = pmk;
        e.inter = pint;
        if (pfill == 0) begin
            add_event(e);
        end else begin
            for (int i = 0; i < pfill; i++) begin
                e.cnt = pfill;
                e.idx = i[3:0];
                e.val = pstore[i[3:0]];
                e.last = (i + 1 == pfill);
                add_event(e);
            end
        end
    endtask

    task automatic decode_utf8(logic [7:0] b);
        if (u_left != 0) begin
            if (b[7:6] == 2'b10) begin
                u_acc = {u_acc[14:0], b[5:0]};
                u_left = u_left - 2'd1;
                if (u_left == 0) add_event(simple_ev(vtp_pkg::K_PRINT, u_acc));
                return;
            end
            u_left = 0;
            u_acc = 0;
        end
        if (b < 8'h80) add_event(simple_ev(vtp_pkg::K_PRINT, {13'd0, b}));
        else if (b[7:5] == 3'b110) begin
            u_acc = {16'd0, b[4:0]};
            u_left = 1;
        end else if (b[7:4] == 4'b1110) begin
            u_acc = {17'd0, b[3:0]};
            u_left = 2;
        end else if (b[7:3] == 5'b11110) begin
            u_acc = {18'd0, b[2:0]};
            u_left = 3;
        end else add_event(simple_ev(vtp_pkg::K_PRINT, vtp_pkg::CP_REPL));
    endtask

    task automatic predict_byte(logic [7:0] b);
        logic fin, c0, intr, dig, sep;
        logic [16:0] acc10;
        fin = (b >= 8'h40 && b <= 8'h7E);
        c0 = (b < 8'h20);
        intr = (b >= 8'h20 && b <= 8'h2F);
        dig = (b >= 8'h30 && b <= 8'h39);
        sep = (b == 8'h3B || b == 8'h3A);
        if (b == vtp_pkg::B_ESC) begin
            u_acc = 0;
            u_left = 0;
            clear_csi();
            pmode = vtp_pkg::M_ESC;
            return;
        end
        if (b == vtp_pkg::B_CAN || b == vtp_pkg::B_SUB) begin
            u_acc = 0;
            u_left = 0;
            pmode = vtp_pkg::M_GROUND;
            return;
        end
        case (pmode)
            vtp_pkg::M_GROUND: begin
                if (c0 || b == 8'h7F) add_event(simple_ev(vtp_pkg::K_EXEC, {13'd0, b}));
                else decode_utf8(b);
            end
            vtp_pkg::M_ESC: begin
                if (intr) pmode = vtp_pkg::M_ESC_INTER;
                else if (b == 8'h5B) begin
                    clear_csi();
                    pmode = vtp_pkg::M_CSI_ENTRY;
                end else if (b == 8'h5D) pmode = vtp_pkg::M_OSC;
                else if (b == 8'h50 || b == 8'h58 || b == 8'h5E || b == 8'h5F)
                    pmode = vtp_pkg::M_STR_IGNORE;
                else if (b >= 8'h30 && b <= 8'h7E) begin
                    pmode = vtp_pkg::M_GROUND;
                    add_event(simple_ev(vtp_pkg::K_ESC, {13'd0, b}));
                end else if (c0) add_event(simple_ev(vtp_pkg::K_EXEC, {13'd0, b}));
                else pmode = vtp_pkg::M_GROUND;
            end
            vtp_pkg::M_ESC_INTER: if (b >= 8'h30 && b <= 8'h7E) pmode = vtp_pkg::M_GROUND;
            vtp_pkg::M_CSI_ENTRY: begin
                if (dig) begin
                    dacc = 16'(b - 8'h30);
                    dseen = 1;
                    pmode = vtp_pkg::M_CSI_PARAM;
                end else if (sep) begin
                    push_param(16'd0);
                    pmode = vtp_pkg::M_CSI_PARAM;
                end else if (b >= 8'h3C && b <= 8'h3F) begin
                    pmk = b;
                    pmode = vtp_pkg::M_CSI_PARAM;
                end else if (intr) begin
                    pint = b;
                    pmode = vtp_pkg::M_CSI_INTER;
                end else if (fin) csi_dispatch(b);
                else if (c0) add_event(simple_ev(vtp_pkg::K_EXEC, {13'd0, b}));
                else pmode = vtp_pkg::M_CSI_IGNORE;
            end
            vtp_pkg::M_CSI_PARAM: begin
                if (dig) begin
                    // saturate at the parameter width
                    acc10 = 17'(dacc * 10) + 17'(b - 8'h30);
                    if (dacc > 16'd6553 || acc10 > 17'h0FFFF) dacc = 16'hFFFF;
                    else dacc = acc10[15:0];
                    dseen = 1;
                end else if (sep) begin
                    push_param(dseen ? dacc : 16'd0);
                    dacc = 0;
                    dseen = 0;
                end else if (intr) begin
                    if (dseen) push_param(dacc);
                    pint = b;
                    pmode = vtp_pkg::M_CSI_INTER;
                end else if (fin) begin
                    if (dseen) push_param(dacc);
                    csi_dispatch(b);
                end else if (c0) add_event(simple_ev(vtp_pkg::K_EXEC, {13'd0, b}));
                else pmode = vtp_pkg::M_CSI_IGNORE;
            end
            vtp_pkg::M_CSI_INTER: begin
                if (fin) csi_dispatch(b);
                else if (c0) add_event(simple_ev(vtp_pkg::K_EXEC, {13'd0, b}));
            end
            vtp_pkg::M_CSI_IGNORE: if (fin) pmode = vtp_pkg::M_GROUND;
            vtp_pkg::M_OSC: begin
                if (b == vtp_pkg::B_BEL || b == vtp_pkg::B_ST) begin
                    pmode = vtp_pkg::M_GROUND;
                    add_event(simple_ev(vtp_pkg::K_OSC, {13'd0, b}));
                end
            end
            vtp_pkg::M_STR_IGNORE:
                if (b == 8'h5C || b == vtp_pkg::B_BEL || b == vtp_pkg::B_ST)
                    pmode = vtp_pkg::M_GROUND;
            default: pmode = vtp_pkg::M_GROUND;
        endcase
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("MISMATCH %s: got %0h want %0h (result %0d)", what, got, want, n_results);
    endtask

    // check accepted results
    always @(posedge aclk) begin
        parse_event_t want;
        logic [TW-1:0] d;
        if (aresetn && m_tvalid && m_tready) begin
            d = m_tdata;
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected result", d, 0);
            end else begin
                want = pending_events.pop_front();
                if (m_tuser != want.kind) report_mismatch("event_kind", m_tuser, want.kind);
                if (d[20:0] != want.code) report_mismatch("code", d[20:0], want.code);
                if (d[28:21] != want.pmark) report_mismatch("private", d[28:21], want.pmark);
                if (d[36:29] != want.inter) report_mismatch("inter", d[36:29], want.inter);
                if (d[41:37] != want.cnt) report_mismatch("param_count", d[41:37], want.cnt);
                if (d[45:42] != want.idx) report_mismatch("param_index", d[45:42], want.idx);
                if (d[61:46] != want.val) report_mismatch("param_value", d[61:46], want.val);
                if (m_tlast != want.last) report_mismatch("last", m_tlast, want.last);
            end
            n_results++;
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        if (!aresetn) m_tready <= 1'b0;
        else if (cycles % 2000 < 400) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_csi_byte();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return 8'(8'h30 + $urandom_range(0, 9));
        if (r < 14) return 8'h3B;
        if (r == 14) return 8'h3A;
        if (r == 15) return 8'(8'h3C + $urandom_range(0, 3));
        if (r == 16) return 8'(8'h20 + $urandom_range(0, 15));
        if (r == 17) return 8'($urandom_range(0, 31));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic build_random();
        int sel, n;
        while (stim.size() < N_ITEMS) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1, 2, 3: begin
                    add_byte(vtp_pkg::B_ESC);
                    add_byte(8'h5B);
                    if ($urandom_range(0, 3) == 0) add_byte(8'(8'h3C + $urandom_range(0, 3)));
                    n = $urandom_range(0, 12);
                    if ($urandom_range(0, 7) == 0) n = 40;
                    repeat (n) add_byte(rand_csi_byte());
                    if ($urandom_range(0, 3) == 0) add_byte(8'(8'h20 + $urandom_range(0, 15)));
                    add_byte(8'(8'h40 + $urandom_range(0, 62)));
                end
                4: begin
                    add_byte(8'(8'hC0 + $urandom_range(0, 63)));
                    repeat ($urandom_range(0, 3)) add_byte(8'(8'h80 + $urandom_range(0, 63)));
                end
                5: begin
                    add_byte(vtp_pkg::B_ESC);
                    add_byte($urandom_range(0, 1) ? 8'h5D : 8'h50);
                    repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(32, 126)));
                    add_byte($urandom_range(0, 1) ? vtp_pkg::B_BEL : vtp_pkg::B_ST);
                end
                6: begin
                    add_byte(vtp_pkg::B_ESC);
                    add_byte(8'($urandom_range(0, 255)));
                    add_byte(8'($urandom_range(0, 255)));
                end
                default: repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        stim_row_t row;
        int idx;
        int gap;
        // typed rows sit in ground with no partial code point: reset print, extremes, controls
        add_row(8'h41, 1'b1, vtp_pkg::K_PRINT, 21'h41);
        add_row(8'h00, 1'b1, vtp_pkg::K_EXEC, 21'h00);
        add_row(8'hFF, 1'b1, vtp_pkg::K_PRINT, vtp_pkg::CP_REPL);
        add_row(8'h80, 1'b1, vtp_pkg::K_PRINT, vtp_pkg::CP_REPL);
        add_row(8'h7F, 1'b1, vtp_pkg::K_EXEC, 21'h7F);
        // multi-byte code points, broken continuation, control inside a code point
        add_byte(8'hE2); add_byte(8'h82); add_byte(8'hAC); add_byte(8'hC3); add_byte(8'h41);
        add_byte(8'hF4); add_byte(8'h8F); add_byte(8'h07); add_byte(8'hBF); add_byte(8'hBF);
        add_str("\033[m\033[?1;;99999999;2 q\033[;H\033c\033]0;t\007\033P\\");
        add_str("\033[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;17;18m");
        add_byte(vtp_pkg::B_ESC); add_byte(8'h5D);
        add_byte(8'h41); add_byte(vtp_pkg::B_ST);
        add_str("\033[12\030Z\033[5\032Z\033[3\033x\033[1\200m\033[1<m");
        build_random();

        pmode = vtp_pkg::M_GROUND; u_acc = 0; u_left = 0; clear_csi();
        foreach (pstore[i]) pstore[i] = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        idx = 0;
        while (idx < stim.size()) begin
            // burst then gap
            repeat ($urandom_range(1, 20)) begin
                if (idx >= stim.size()) break;
                row = stim[idx];
                s_tvalid <= 1'b1;
                s_tdata <= row.din;
                @(posedge aclk);
                while (!s_tready) @(posedge aclk);
                if (row.typed) add_event(simple_ev(row.kind, row.code));
                else predict_byte(row.din);
                idx++;
            end
            gap = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("covered %0d bytes, %0d results including %0d CSI dispatches",
                 stim.size(), n_results, n_csi);
        $display("UTF-8, controls, ESC/CSI/OSC/string sequences, stalls on both sides");
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
+incdir+hw/rtl
hw/rtl/vtp_pkg.sv
hw/rtl/vtp_front.sv
hw/rtl/vtp_back.sv
hw/rtl/vt_escape_sequence_parser.sv
tb/tb.sv
